// ----- design/fla_pkg.sv -----
// Shared types and constants of the free-list buffer allocator.
`default_nettype none

package fla_pkg;

  // Default pool size.
  localparam int DefPoolDepth = 64;

  // Command codes.
  localparam logic CmdAcquire = 1'b0;
  localparam logic CmdRelease = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusEmpty  = 2'd1,
    StatusRange  = 2'd2,
    StatusFree   = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic {
    StIdle,
    StExec
  } fsm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // item taken this cycle; latch it and start the stack read
    logic commit;  // apply the item and load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_stall;  // result register full and not taken this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/fla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/fla_ctrl.sv -----
// Controller state machine of the free-list buffer allocator.
`default_nettype none

module fla_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fla_pkg::dp_stat_t stat_i,
  output fla_pkg::ctl_cmd_t      cmd_o
);

  import fla_pkg::*;

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        // hold until the result register has room
        if (!stat_i.out_stall) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      StExec: begin
        cmd_o.commit = !stat_i.out_stall;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/fla_datapath.sv -----
// Datapath: free stack, busy bits, stack pointer and result register.
`default_nettype none

module fla_datapath #(
  parameter int POOL_DEPTH = fla_pkg::DefPoolDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fla_pkg::ctl_cmd_t cmd_i,
  output fla_pkg::dp_stat_t      stat_o,
  input  wire logic              command_i,
  input  wire logic [7:0]        entry_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             status_o,
  output logic [5:0]             granted_index_o,
  output logic [6:0]             free_count_o
);

  import fla_pkg::*;

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int TW = $clog2(POOL_DEPTH + 1);

  logic [TW-1:0]         top_q, top_d;
  logic [POOL_DEPTH-1:0] busy_q, busy_d;
  logic [POOL_DEPTH-1:0] vld_q, vld_d;
  logic                  cmd_q;
  logic [7:0]            idx_q;
  logic                  rd_vld_q;
  logic [IW-1:0]         rd_addr_q;
  logic [IW-1:0]         ram_rdata;
  logic [TW-1:0]         top_minus;
  logic [IW-1:0]         raddr;
  logic [IW-1:0]         got;
  logic [IW-1:0]         idx_w;
  logic                  idx_in_range;
  logic                  push_room;
  logic                  ram_we;
  status_e               status_d;
  logic [IW-1:0]         granted_d;
  logic [8:0]            granted_pad;
  logic [8:0]            top_pad;
  logic                  out_valid_q;
  logic [1:0]            status_q;
  logic [5:0]            granted_q;
  logic [6:0]            free_count_q;

  // Stack read is issued on accept; the top entry sits at top - 1.
  assign top_minus = top_q - TW'(1);
  assign raddr     = top_minus[IW-1:0];

  fla_ram #(
    .WIDTH (IW),
    .DEPTH (POOL_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (top_q[IW-1:0]),
    .wdata_i (idx_w),
    .re_i    (cmd_i.accept),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q     <= command_i;
      idx_q     <= entry_index_i;
      rd_vld_q  <= vld_q[raddr];
      rd_addr_q <= raddr;
    end
  end

  // A stack slot never written still holds its own position.
  assign got          = rd_vld_q ? ram_rdata : rd_addr_q;
  assign idx_w        = idx_q[IW-1:0];
  assign idx_in_range = {1'b0, idx_q} < 9'(POOL_DEPTH);
  assign push_room    = top_q < TW'(POOL_DEPTH);

  always_comb begin
    top_d     = top_q;
    busy_d    = busy_q;
    vld_d     = vld_q;
    ram_we    = 1'b0;
    status_d  = StatusOk;
    granted_d = '0;
    case (cmd_q)
      CmdAcquire: begin
        if (top_q == '0) begin
          status_d = StatusEmpty;
        end else begin
          granted_d   = got;
          top_d       = top_minus;
          busy_d[got] = 1'b1;
        end
      end
      default: begin
        if (!idx_in_range) begin
          status_d = StatusRange;
        end else if (!busy_q[idx_w]) begin
          status_d = StatusFree;
        end else begin
          busy_d[idx_w] = 1'b0;
          if (push_room) begin
            ram_we              = cmd_i.commit;
            vld_d[top_q[IW-1:0]] = 1'b1;
            top_d               = top_q + TW'(1);
          end
        end
      end
    endcase
  end

  assign granted_pad = 9'(granted_d);
  assign top_pad     = 9'(top_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= TW'(POOL_DEPTH);
      busy_q      <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        top_q       <= top_d;
        busy_q      <= busy_d;
        vld_q       <= vld_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= status_d;
      granted_q    <= granted_pad[5:0];
      free_count_q <= top_pad[6:0];
    end
  end

  assign stat_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_index_o  = granted_q;
  assign free_count_o     = free_count_q;

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TW'(POOL_DEPTH))
    else $error("stack pointer beyond pool");

  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(busy_q) + int'(top_q)) == POOL_DEPTH)
    else $error("busy plus free entries do not add up to the pool");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before taken");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed item has no result");

endmodule

`default_nettype wire

// ----- design/free_list_buffer_allocator_core.sv -----
// Top level of the free-list buffer allocator.
//
// Input channel (in_valid_i/in_ready_o) carries one command per item:
// command_i = 0 acquires a free entry, command_i = 1 releases entry_index_i.
// Output channel (out_valid_o/out_ready_i) returns one result per item:
// status_o, granted_index_o and the free count after the command.
// In the cycle an item is accepted it issues a read of the free stack RAM at
// the top of stack; in the execute state it uses the registered read data
// and updates stack pointer, busy bits and the result register.
// The result register loads when the item commits in the execute state.
// A new item is accepted only in the idle state, due to the registered read
// port of the stack RAM. While a result waits in the output register, the
// next item is still accepted; it holds in execute until the result is taken.
// Reset frees all entries at once (no clearing pass); the first acquire
// returns index POOL_DEPTH-1.
`default_nettype none

module free_list_buffer_allocator_core #(
  parameter int POOL_DEPTH = fla_pkg::DefPoolDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       command_i,
  input  wire logic [7:0] entry_index_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [5:0]      granted_index_o,
  output logic [6:0]      free_count_o
);

  import fla_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  fla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fla_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .free_count_o    (free_count_o)
  );

endmodule

`default_nettype wire
